>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the cross pixel generator RTL, included by vcp_emit.
// Each macro samples on aclk and is switched off while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// The consequent must hold in the cycle after the antecedent.
`define VCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

>>> sv/vcp_pkg.sv
// ---------------------------------------------------------------------------
// vcp_pkg
// Constants, codes and types shared by the cross pixel generator modules.
// ---------------------------------------------------------------------------
package vcp_pkg;

    localparam int DISPLAY_WIDTH  = 240;
    localparam int DISPLAY_HEIGHT = 320;
    localparam int LINE_THICKNESS = 2;

    // Pixels written for one scan position.
    localparam int NUM_PIX = 1 + 2 * LINE_THICKNESS;
    localparam int CNT_W   = (NUM_PIX > 1) ? $clog2(NUM_PIX) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_PIX - 1);

    // Scan phases.
    localparam logic [1:0] PH_XARM   = 2'd0;
    localparam logic [1:0] PH_YARM   = 2'd1;
    localparam logic [1:0] PH_ORIGIN = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_SCALE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FG_COLOR   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_COLOR   = 3'd4;

    typedef struct packed {
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [15:0] full_scale;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
    } vcp_cfg_t;

    // One scan position that produces pixel writes.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pos;
        logic [15:0] color;
    } vcp_desc_t;

endpackage

>>> sv/vector_cross_pixel_generator.sv
// ---------------------------------------------------------------------------
// vector_cross_pixel_generator
// Draws a 2D vector as a thick cross of pixel writes around an origin.
//
//   channel   ports       role
//   input     s_axis_*    load (tuser 0) or advance (tuser 1) transactions
//   result    m_axis_*    pixel write transactions, tlast ends one step
//   config    cfg_*       register writes, one per cycle, no read-back
//
// A load or an advance that draws nothing causes no pixel write. An advance
// that draws causes 1 + 2*LINE_THICKNESS pixel writes (5), which the emitter
// writes one per cycle while the result channel is not stalled. One drawable
// step waits in the descriptor register while the emitter is busy, so the
// input stalls only when both are full. Reset is synchronous; after it the
// scan is done and advances draw nothing until a load.
// ---------------------------------------------------------------------------
module vector_cross_pixel_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // x_comp, y_comp
    input  logic [0:0]                     s_axis_tuser,  // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [47:0]                    m_axis_tdata,  // pix_x, pix_y, pix_color
    output logic [1:0]                     m_axis_tuser,  // off_screen, figure_done
    output logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [vcp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]                    cfg_wdata
);
    import vcp_pkg::*;

    vcp_cfg_t  cfg;
    logic      desc_valid;
    vcp_desc_t desc;
    logic      desc_take;

    vcp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vcp_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_func     (s_axis_tuser[0]),
        .s_x_comp   (s_axis_tdata[15:0]),
        .s_y_comp   (s_axis_tdata[31:16]),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take)
    );

    vcp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_take  (desc_take),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast)
    );

endmodule

>>> sv/vcp_cfg.sv
// ---------------------------------------------------------------------------
// vcp_cfg
// Configuration register file with a plain write port.
// ---------------------------------------------------------------------------
module vcp_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [vcp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    output vcp_pkg::vcp_cfg_t              cfg
);
    import vcp_pkg::*;

    vcp_cfg_t cfg_reg;
    vcp_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_CENTER_X:   cfg_next.center_x   = cfg_wdata;
                REG_CENTER_Y:   cfg_next.center_y   = cfg_wdata;
                REG_FULL_SCALE: cfg_next.full_scale = cfg_wdata;
                REG_FG_COLOR:   cfg_next.fg_color   = cfg_wdata;
                REG_BG_COLOR:   cfg_next.bg_color   = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x   <= 16'd120;
            cfg_reg.center_y   <= 16'd160;
            cfg_reg.full_scale <= 16'd100;
            cfg_reg.fg_color   <= 16'hFFFF;
            cfg_reg.bg_color   <= 16'h0000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/vcp_scan.sv
// ---------------------------------------------------------------------------
// vcp_scan
// Scan sequencer: latches the vector on a load, walks the arms and the
// origin on each advance and hands drawable positions to the emitter.
// ---------------------------------------------------------------------------
module vcp_scan (
    input  logic               aclk,
    input  logic               aresetn,
    input  vcp_pkg::vcp_cfg_t  cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [15:0]        s_x_comp,
    input  logic [15:0]        s_y_comp,
    output logic               desc_valid,
    output vcp_pkg::vcp_desc_t desc,
    input  logic               desc_take
);
    import vcp_pkg::*;

    logic [15:0] vec_x_reg, vec_x_next;
    logic [15:0] vec_y_reg, vec_y_next;
    logic [15:0] tip_x_reg, tip_x_next;
    logic [15:0] tip_y_reg, tip_y_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic        desc_valid_reg, desc_valid_next;
    vcp_desc_t   desc_reg, desc_next;

    logic [15:0] half, xl, xh, yl, yh;
    logic [1:0]  ph;
    logic [15:0] pos;
    logic        fg_x, fg_y, has_pix, accept;
    logic [15:0] step_color;
    logic [1:0]  step_phase;
    logic [15:0] step_pos;

    assign s_ready = !desc_valid_reg || desc_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        half = cfg.full_scale >> 1;
        xl   = cfg.center_x - half;
        xh   = cfg.center_x + half;
        yl   = cfg.center_y - half;
        yh   = cfg.center_y + half;

        // Arm ends are rechecked with the live registers before each step.
        ph  = phase_reg;
        pos = pos_reg;
        if (ph == PH_XARM && !(pos < xh)) begin
            ph  = PH_YARM;
            pos = yl;
        end
        if (ph == PH_YARM && !(pos < yh)) begin
            ph = PH_ORIGIN;
        end

        // A negative component is drawn from the tip up to the center.
        fg_x = vec_x_reg[15] ? (tip_x_reg <= pos && pos <= cfg.center_x)
                             : (cfg.center_x <= pos && pos <= tip_x_reg);
        fg_y = vec_y_reg[15] ? (tip_y_reg <= pos && pos <= cfg.center_y)
                             : (cfg.center_y <= pos && pos <= tip_y_reg);

        case (ph)
            PH_XARM: begin
                has_pix    = (vec_x_reg != 16'd0) && (pos != cfg.center_x);
                step_color = fg_x ? cfg.fg_color : cfg.bg_color;
                step_phase = ph;
                step_pos   = pos + 16'd1;
            end
            PH_YARM: begin
                has_pix    = (vec_y_reg != 16'd0) && (pos != cfg.center_y);
                step_color = fg_y ? cfg.fg_color : cfg.bg_color;
                step_phase = ph;
                step_pos   = pos + 16'd1;
            end
            PH_ORIGIN: begin
                has_pix    = 1'b1;
                step_color = cfg.fg_color;
                step_phase = PH_DONE;
                step_pos   = pos;
            end
            default: begin
                has_pix    = 1'b0;
                step_color = cfg.fg_color;
                step_phase = ph;
                step_pos   = pos;
            end
        endcase

        vec_x_next      = vec_x_reg;
        vec_y_next      = vec_y_reg;
        tip_x_next      = tip_x_reg;
        tip_y_next      = tip_y_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        desc_next       = desc_reg;
        desc_valid_next = desc_valid_reg && !desc_take;

        if (accept) begin
            if (!s_func) begin
                vec_x_next = s_x_comp;
                vec_y_next = s_y_comp;
                tip_x_next = cfg.center_x + s_x_comp;
                tip_y_next = cfg.center_y + s_y_comp;
                phase_next = PH_XARM;
                pos_next   = xl;
            end else begin
                phase_next = step_phase;
                pos_next   = step_pos;
                if (has_pix) begin
                    desc_valid_next = 1'b1;
                    desc_next.kind  = ph;
                    desc_next.pos   = pos;
                    desc_next.color = step_color;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_x_reg      <= 16'd0;
            vec_y_reg      <= 16'd0;
            tip_x_reg      <= 16'd0;
            tip_y_reg      <= 16'd0;
            phase_reg      <= PH_DONE;
            pos_reg        <= 16'd0;
            desc_valid_reg <= 1'b0;
        end else begin
            vec_x_reg      <= vec_x_next;
            vec_y_reg      <= vec_y_next;
            tip_x_reg      <= tip_x_next;
            tip_y_reg      <= tip_y_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            desc_valid_reg <= desc_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

    assign desc_valid = desc_valid_reg;
    assign desc       = desc_reg;

endmodule

>>> sv/vcp_emit.sv
// ---------------------------------------------------------------------------
// vcp_emit
// Pixel emitter: expands one scan position into its pixel writes, one per
// cycle unless the result channel stalls, into its output register.
// ---------------------------------------------------------------------------
module vcp_emit (
    input  logic               aclk,
    input  logic               aresetn,
    input  vcp_pkg::vcp_cfg_t  cfg,
    input  logic               desc_valid,
    input  vcp_pkg::vcp_desc_t desc,
    output logic               desc_take,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);
    import vcp_pkg::*;
    `include "assert_macros.svh"

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    vcp_desc_t        cur_reg, cur_next;
    logic             m_valid_reg, m_valid_next;
    logic [47:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             m_tlast_reg;

    logic        adv, fin, take, is_last;
    logic [15:0] kk, mag, delta, px, py;
    logic        done_flag, off;

    always_comb begin
        adv     = busy_reg && (!m_valid_reg || m_tready);
        is_last = (cnt_reg == CNT_LAST);
        fin     = adv && is_last;
        take    = desc_valid && (!busy_reg || fin);

        // Arm pixels alternate above and below the axis: 0, +1, -1, +2, -2.
        kk    = 16'(cnt_reg);
        mag   = (kk + 16'd1) >> 1;
        delta = cnt_reg[0] ? mag : (16'd0 - mag);

        done_flag = 1'b0;
        case (cur_reg.kind)
            PH_XARM: begin
                px = cur_reg.pos;
                py = cfg.center_y + delta;
            end
            PH_YARM: begin
                px = cfg.center_x + delta;
                py = cur_reg.pos;
            end
            default: begin
                // Origin: a run to the right, then a run downward.
                if (kk <= 16'(LINE_THICKNESS)) begin
                    px = cfg.center_x + kk;
                    py = cfg.center_y;
                end else begin
                    px = cfg.center_x;
                    py = cfg.center_y + kk - 16'(LINE_THICKNESS);
                end
                done_flag = is_last;
            end
        endcase
        off = (px >= 16'(DISPLAY_WIDTH)) || (py >= 16'(DISPLAY_HEIGHT));

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        if (take) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            cur_next  = desc;
        end else if (fin) begin
            busy_next = 1'b0;
        end else if (adv) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        m_valid_next = adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (adv) begin
            m_tdata_reg <= {cur_reg.color, py, px};
            m_tuser_reg <= {done_flag, off};
            m_tlast_reg <= is_last;
        end
    end

    assign desc_take = take;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

    `VCP_ASSERT_IMP(a_done_on_last, m_valid_reg && m_tuser_reg[1], m_tlast_reg)
    `VCP_ASSERT_IMP(a_cnt_in_range, busy_reg, cnt_reg <= CNT_LAST)
    `VCP_ASSERT_NXT(a_take_restarts, take, busy_reg && cnt_reg == '0)

endmodule

>>> bench/cross_pixel_checker.sv
// ---------------------------------------------------------------------------
// cross_pixel_checker
// Watches the input, result and register ports of the cross pixel generator.
// It keeps its own copy of the registers and of the scan state, works out the
// pixel writes that every accepted input transaction must cause, and compares
// each accepted pixel write with the oldest one still due.
// ---------------------------------------------------------------------------
module cross_pixel_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,  // x_comp, y_comp
    input  logic [0:0]                     s_axis_tuser,  // func
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [47:0]                    m_axis_tdata,  // pix_x, pix_y, pix_color
    input  logic [1:0]                     m_axis_tuser,  // off_screen, figure_done
    input  logic                           m_axis_tlast,
    input  logic                           cfg_we,
    input  logic [vcp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [15:0]                    cfg_wdata,
    output int                             mismatch_count,
    output int                             pending_count,
    output int                             pixel_count,
    output int                             figure_count
);
    import vcp_pkg::*;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] color;
        logic        off_screen;
        logic        last_of_step;
        logic        figure_done;
    } pixel_t;

    pixel_t      pixels_due[$];
    pixel_t      step_buf[NUM_PIX];
    int          step_n;
    vcp_cfg_t    regs;
    logic [15:0] comp_x, comp_y, tip_col, tip_row, scan_at;
    logic [1:0]  scan_ph;
    int          n_bad, n_pix, n_fig;

    task automatic stage(input logic [15:0] x, input logic [15:0] y, input logic [15:0] c);
        logic off;
        off = (x >= DISPLAY_WIDTH) || (y >= DISPLAY_HEIGHT);
        step_buf[step_n] = {x, y, c, off, 1'b0, 1'b0};
        step_n++;
    endtask

    // Bit 16 says whether the position draws at all, the rest is its color.
    function automatic logic [16:0] arm_shade(input logic [15:0] comp, input logic [15:0] tip,
                                              input logic [15:0] ctr, input logic [15:0] p);
        logic in_vec;
        if (comp == 16'd0 || p == ctr)
            return 17'd0;
        if (comp[15])
            in_vec = (tip <= p) && (p <= ctr);
        else
            in_vec = (ctr <= p) && (p <= tip);
        return {1'b1, in_vec ? regs.fg_color : regs.bg_color};
    endfunction

    task automatic draw_step(input logic advance, input logic [15:0] xc, input logic [15:0] yc);
        logic [15:0] half, xl, xh, yl, yh;
        logic [16:0] shade;
        int t;
        half = regs.full_scale >> 1;
        xl = regs.center_x - half;
        xh = regs.center_x + half;
        yl = regs.center_y - half;
        yh = regs.center_y + half;
        step_n = 0;
        if (!advance) begin
            comp_x  = xc;
            comp_y  = yc;
            tip_col = regs.center_x + xc;
            tip_row = regs.center_y + yc;
            scan_ph = PH_XARM;
            scan_at = xl;
        end else begin
            // Arm ends are checked again with the registers as they are now.
            if (scan_ph == PH_XARM && !(scan_at < xh)) begin
                scan_ph = PH_YARM;
                scan_at = yl;
            end
            if (scan_ph == PH_YARM && !(scan_at < yh))
                scan_ph = PH_ORIGIN;
            case (scan_ph)
                PH_XARM: begin
                    shade = arm_shade(comp_x, tip_col, regs.center_x, scan_at);
                    if (shade[16]) begin
                        stage(scan_at, regs.center_y, shade[15:0]);
                        for (t = 1; t <= LINE_THICKNESS; t++) begin
                            stage(scan_at, 16'(regs.center_y + t), shade[15:0]);
                            stage(scan_at, 16'(regs.center_y - t), shade[15:0]);
                        end
                    end
                    scan_at = scan_at + 16'd1;
                end
                PH_YARM: begin
                    shade = arm_shade(comp_y, tip_row, regs.center_y, scan_at);
                    if (shade[16]) begin
                        stage(regs.center_x, scan_at, shade[15:0]);
                        for (t = 1; t <= LINE_THICKNESS; t++) begin
                            stage(16'(regs.center_x + t), scan_at, shade[15:0]);
                            stage(16'(regs.center_x - t), scan_at, shade[15:0]);
                        end
                    end
                    scan_at = scan_at + 16'd1;
                end
                PH_ORIGIN: begin
                    stage(regs.center_x, regs.center_y, regs.fg_color);
                    for (t = 1; t <= LINE_THICKNESS; t++)
                        stage(16'(regs.center_x + t), regs.center_y, regs.fg_color);
                    for (t = 1; t <= LINE_THICKNESS; t++)
                        stage(regs.center_x, 16'(regs.center_y + t), regs.fg_color);
                    step_buf[step_n-1].figure_done = 1'b1;
                    scan_ph = PH_DONE;
                end
                default: begin
                end
            endcase
        end
        if (step_n > 0)
            step_buf[step_n-1].last_of_step = 1'b1;
        for (t = 0; t < step_n; t++)
            pixels_due.push_back(step_buf[t]);
    endtask

    always @(posedge aclk) begin
        pixel_t want, got;
        if (!aresetn) begin
            regs.center_x   = 16'd120;
            regs.center_y   = 16'd160;
            regs.full_scale = 16'd100;
            regs.fg_color   = 16'hFFFF;
            regs.bg_color   = 16'h0000;
            comp_x  = '0;
            comp_y  = '0;
            tip_col = '0;
            tip_row = '0;
            scan_at = '0;
            scan_ph = PH_DONE;
            pixels_due.delete();
            n_bad = 0;
            n_pix = 0;
            n_fig = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CENTER_X:   regs.center_x   = cfg_wdata;
                    REG_CENTER_Y:   regs.center_y   = cfg_wdata;
                    REG_FULL_SCALE: regs.full_scale = cfg_wdata;
                    REG_FG_COLOR:   regs.fg_color   = cfg_wdata;
                    REG_BG_COLOR:   regs.bg_color   = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                draw_step(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16]);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
                       m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
                if (pixels_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected pixel write: x=%0d y=%0d color=%h off=%b last=%b done=%b",
                                 got.x, got.y, got.color, got.off_screen, got.last_of_step,
                                 got.figure_done);
                end else begin
                    want = pixels_due.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("pixel write %0d mismatch: expected x=%0d y=%0d color=%h ",
                                     n_pix, want.x, want.y, want.color,
                                     "off=%b last=%b done=%b, got x=%0d y=%0d color=%h ",
                                     want.off_screen, want.last_of_step, want.figure_done,
                                     got.x, got.y, got.color,
                                     "off=%b last=%b done=%b",
                                     got.off_screen, got.last_of_step, got.figure_done);
                    end
                end
                n_pix++;
                if (got.figure_done)
                    n_fig++;
            end
        end
        mismatch_count <= n_bad;
        pending_count  <= pixels_due.size();
        pixel_count    <= n_pix;
        figure_count   <= n_fig;
    end

endmodule

>>> bench/tb_vector_cross_pixel_generator.sv
// ---------------------------------------------------------------------------
// tb_vector_cross_pixel_generator
// Drives load and advance transactions into the cross pixel generator under
// a series of register settings, with random idling on both channels, and
// takes the verdict from the pixel checker that runs beside the block.
// ---------------------------------------------------------------------------
module tb_vector_cross_pixel_generator;
    import vcp_pkg::*;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;
    localparam int   RANDOM_ITEMS = 430;
    localparam int   CALM_ITEMS   = 70;
    localparam int   PHASE_ITEMS  = 45;
    localparam int   LONG_HOLD    = 300;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   DRAIN_LIMIT  = 50000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [47:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [15:0]           cfg_wdata;

    int mismatches, pending, pixels_seen, figures_seen;
    int n_loads, n_advances, n_settings;
    bit calm, hold_req, hold_done;
    logic [15:0] cur_cx, cur_cy, cur_fs;

    vector_cross_pixel_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    cross_pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .pixel_count    (pixels_seen),
        .figure_count   (figures_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d pixel writes still due", pending);
        $display("tb_vector_cross_pixel_generator NOT OK");
        $finish;
    end

    // Pixel write receiver: random ready bursts, plus one long hold-off that
    // lets the block fill up while the sender keeps offering.
    initial begin : pixel_sink
        int burst;
        bit stall;
        burst = 0;
        stall = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (burst == 0) begin
                stall = !calm && ($urandom_range(0, 2) == 0);
                burst = $urandom_range(1, 15);
            end
            m_axis_tready <= !stall;
            burst--;
            @(posedge aclk);
        end
    end

    task automatic offer(input logic func, input logic [15:0] xc, input logic [15:0] yc);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {yc, xc};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (func == FUNC_LOAD)
            n_loads++;
        else
            n_advances++;
    endtask

    task automatic advance_n(input int n);
        int k;
        for (k = 0; k < n; k++)
            offer(FUNC_ADVANCE, 16'($urandom), 16'($urandom));
    endtask

    // Stop offering and wait until every pixel write that is due has come.
    task automatic settle();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic write_regs(input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] fs, input logic [15:0] fg,
                              input logic [15:0] bg);
        settle();
        put_reg(REG_CENTER_X, cx);
        put_reg(REG_CENTER_Y, cy);
        put_reg(REG_FULL_SCALE, fs);
        put_reg(REG_FG_COLOR, fg);
        put_reg(REG_BG_COLOR, bg);
        cfg_we <= 1'b0;
        cur_cx = cx;
        cur_cy = cy;
        cur_fs = fs;
        n_settings++;
    endtask

    // Number of advances from a load until the figure is finished.
    function automatic int figure_steps(input logic [15:0] cx, input logic [15:0] cy,
                                        input logic [15:0] fs);
        logic [15:0] half, xl, xh, yl, yh;
        int n;
        half = fs >> 1;
        xl = cx - half;
        xh = cx + half;
        yl = cy - half;
        yh = cy + half;
        n = 1;
        if (xl < xh)
            n += xh - xl;
        if (yl < yh)
            n += yh - yl;
        return n;
    endfunction

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(0, 6))
            0: return 16'h0000;
            1: return ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
            2, 3, 4: return 16'($urandom_range(0, 24) - 12);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_center(input int span);
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [15:0] pick_color();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic new_setting(input int idx);
        logic [15:0] fs;
        case (idx)
            0: write_regs(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
            1: write_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
            2: write_regs(16'd1, 16'd319, 16'd6, pick_color(), pick_color());
            3: write_regs(16'd238, 16'd3, 16'd12, pick_color(), pick_color());
            default: begin
                case ($urandom_range(0, 9))
                    0: fs = 16'd0;
                    1: fs = 16'd1;
                    2: fs = 16'($urandom_range(30, 40));
                    default: fs = 16'($urandom_range(2, 16));
                endcase
                write_regs(pick_center(250), pick_center(330), fs, pick_color(), pick_color());
            end
        endcase
    endtask

    // Mostly complete figures with random vectors; some scans are cut short
    // by a new load, and a few transactions are plain noise.
    task automatic run_phase(input int budget);
        int used, steps, r, n, k;
        used = 0;
        while (used < budget) begin
            r = $urandom_range(0, 9);
            steps = figure_steps(cur_cx, cur_cy, cur_fs);
            if (r < 7) begin
                n = steps + $urandom_range(0, 2);
                offer(FUNC_LOAD, pick_comp(), pick_comp());
                advance_n(n);
                used += n + 1;
            end else if (r < 9) begin
                n = $urandom_range(0, steps - 1);
                offer(FUNC_LOAD, pick_comp(), pick_comp());
                advance_n(n);
                used += n + 1;
            end else begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    offer(1'($urandom), 16'($urandom), 16'($urandom));
                used += n;
            end
        end
    endtask

    initial begin : stimulus
        int idx, random_start;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_wdata     <= '0;
        n_loads    = 0;
        n_advances = 0;
        n_settings = 0;
        cur_cx = 16'd120;
        cur_cy = 16'd160;
        cur_fs = 16'd100;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // An advance right after reset draws nothing; then a short scan
        // under the reset register values.
        offer(FUNC_ADVANCE, 16'hFFFF, 16'hFFFF);
        offer(FUNC_LOAD, 16'd5, 16'hFFFB);
        advance_n(3);
        // New registers in the middle of a scan: the x arm is already past
        // its new end, while the latched tip stays where it was.
        write_regs(16'd10, 16'd318, 16'd8, 16'hF800, 16'h07E0);
        advance_n(1);
        // A whole small figure with rows running off the bottom edge.
        offer(FUNC_LOAD, 16'd3, 16'hFFFE);
        advance_n(figure_steps(cur_cx, cur_cy, cur_fs));
        offer(FUNC_LOAD, 16'h7FFF, 16'h8000);
        advance_n(1);

        idx = 0;
        random_start = n_loads + n_advances;
        while (n_loads + n_advances - random_start < RANDOM_ITEMS) begin
            if (n_loads + n_advances - random_start >= RANDOM_ITEMS - CALM_ITEMS)
                calm <= 1'b1;
            new_setting(idx);
            if (idx == 3)
                hold_req <= 1'b1;
            run_phase(PHASE_ITEMS);
            idx++;
        end
        settle();

        $display("Covered %0d loads and %0d advances under %0d register settings;",
                 n_loads, n_advances, n_settings);
        $display("%0d pixel writes checked, %0d figures finished, %0d mismatches, %0d left due.",
                 pixels_seen, figures_seen, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("tb_vector_cross_pixel_generator OK");
        else
            $display("tb_vector_cross_pixel_generator NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/vcp_pkg.sv
sv/vcp_cfg.sv
sv/vcp_scan.sv
sv/vcp_emit.sv
sv/vector_cross_pixel_generator.sv
bench/cross_pixel_checker.sv
bench/tb_vector_cross_pixel_generator.sv
